@@ hdl/fmp_pkg.sv @@
// Package for the FFT magnitude and phase core: constants, CORDIC arctangent table,
// twiddle generator and sequencer state types.
// Used by fmp_polar and fft_magnitude_phase_core; depends on nothing.
`default_nettype none

package fmp_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 4;
    localparam int SAMPLE_W        = 16;
    localparam int BIN_W           = 9;
    localparam int MAG_BITS        = 26;
    localparam int PHASE_BITS      = 16;
    localparam int TW_FRAC         = 30;
    localparam int CORDIC_STEPS    = 30;
    localparam int MIN_LOG2        = 3;
    localparam int NORM_TOP        = 58;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint MAG_MAX         = 64'sd67108863;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BR_CHK,
        ST_BR_RD_P,
        ST_BR_RD_R,
        ST_BR_WR_P,
        ST_BR_WR_R,
        ST_BF_RD_HI,
        ST_BF_RD_LO,
        ST_BF_M0,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_M4,
        ST_BF_RND,
        ST_BF_WR_LO,
        ST_BF_WR_HI,
        ST_RD_LATCH,
        ST_RD_POLAR,
        ST_RD_OUT
    } fmp_state_t;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_SQ_RE,
        PS_SQ_IM,
        PS_SUM,
        PS_NORM,
        PS_ITER,
        PS_FIN
    } polar_state_t;

    // Twiddle k of a table built for 2^top points, as {sin, cos} in Q2.30.
    function automatic logic [63:0] tw_entry(input int k, input int top);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic flip;
        a = longint'(k) <<< (32 - top);
        flip = (a > (64'sd1 <<< 30));
        z = flip ? ((64'sd1 <<< 31) - a) : a;
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
        end
        if (flip) begin
            x = -x;
        end
        return {y[31:0], x[31:0]};
    endfunction

endpackage

`default_nettype wire

@@ hdl/fmp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the complex work store of the FFT core; no dependencies.
`default_nettype none

module fmp_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/fmp_polar.sv @@
// Iterative magnitude and phase unit: integer square root of re^2 + im^2 and
// CORDIC vectoring for atan2, one step per cycle. Depends on fmp_pkg.
`default_nettype none

module fmp_polar #(
    parameter int PART_BITS = 27
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [PART_BITS-1:0]          re,
    input  wire logic signed [PART_BITS-1:0]          im,
    output logic                                      done,
    output logic        [fmp_pkg::MAG_BITS-1:0]       magnitude,
    output logic signed [fmp_pkg::PHASE_BITS-1:0]     phase
);
    import fmp_pkg::*;

    localparam int SW     = 2 * PART_BITS;
    localparam int ITERS  = (PART_BITS > CORDIC_STEPS) ? PART_BITS : CORDIC_STEPS;
    localparam int CW     = $clog2(ITERS + 1);
    localparam int PRE_SH = NORM_TOP + 1 - PART_BITS;

    polar_state_t state_reg, state_next;

    logic signed [PART_BITS-1:0] re_reg, im_reg;
    logic signed [63:0]          x_reg, y_reg, z_reg;
    logic        [SW-1:0]        sq_reg, n_reg, r_reg, bit_reg;
    logic        [CW-1:0]        cnt_reg;
    logic        [MAG_BITS-1:0]  mag_reg;
    logic signed [PHASE_BITS-1:0] phase_reg;

    logic               re_zero, im_zero, special, below_top;
    logic signed [PART_BITS-1:0] sq_op;
    logic signed [SW-1:0] sq_prod;
    logic signed [63:0] dx, dy, zt, pq;
    logic        [SW-1:0] rb, rr;
    logic signed [63:0] x0, y0, lim;

    assign re_zero   = (re_reg == '0);
    assign im_zero   = (im_reg == '0);
    assign special   = re_zero || im_zero;
    assign lim       = 64'sd1 <<< NORM_TOP;
    assign below_top = (x_reg < lim) && (y_reg < lim) && (y_reg > -lim);
    assign sq_op     = (state_reg == PS_SQ_RE) ? re_reg : im_reg;
    assign sq_prod   = sq_op * sq_op;
    assign dx        = y_reg >>> cnt_reg;
    assign dy        = x_reg >>> cnt_reg;
    assign rb        = r_reg + bit_reg;
    assign rr        = r_reg + SW'(n_reg > r_reg);
    assign zt        = (z_reg <<< 15) - z_reg + (64'sd1 <<< 30);
    assign pq        = zt >>> 31;
    assign x0        = (re_reg < 0) ? -64'(re_reg) : 64'(re_reg);
    assign y0        = (re_reg < 0) ? -64'(im_reg) : 64'(im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            PS_IDLE:
            begin
                if (start)
                begin
                    state_next = PS_SQ_RE;
                end
            end
            PS_SQ_RE: state_next = PS_SQ_IM;
            PS_SQ_IM: state_next = PS_SUM;
            PS_SUM:   state_next = PS_NORM;
            PS_NORM:
            begin
                if (special || !below_top)
                begin
                    state_next = PS_ITER;
                end
            end
            PS_ITER:
            begin
                if (cnt_reg == CW'(ITERS - 1))
                begin
                    state_next = PS_FIN;
                end
            end
            PS_FIN:
            begin
                done       = 1'b1;
                state_next = PS_IDLE;
            end
            default: state_next = PS_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            PS_IDLE:
            begin
                if (start)
                begin
                    re_reg <= re;
                    im_reg <= im;
                end
            end
            PS_SQ_RE:
            begin
                sq_reg <= sq_prod;
                x_reg  <= x0 <<< PRE_SH;
                y_reg  <= y0 <<< PRE_SH;
                if (re_reg < 0)
                begin
                    z_reg <= (im_reg > 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
                end
                else
                begin
                    z_reg <= '0;
                end
            end
            PS_SQ_IM:
            begin
                sq_reg <= sq_prod;
                n_reg  <= sq_reg;
            end
            PS_SUM:
            begin
                n_reg   <= n_reg + sq_reg;
                r_reg   <= '0;
                bit_reg <= SW'(1) << (SW - 2);
                cnt_reg <= '0;
            end
            PS_NORM:
            begin
                if (!special && below_top)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            PS_ITER:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg < CW'(PART_BITS))
                begin
                    if (n_reg >= rb)
                    begin
                        n_reg <= n_reg - rb;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                if (!special && cnt_reg < CW'(CORDIC_STEPS))
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ATAN_TAB[cnt_reg[4:0]];
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ATAN_TAB[cnt_reg[4:0]];
                    end
                end
            end
            PS_FIN:
            begin
                mag_reg <= (64'(rr) > MAG_MAX) ? MAG_BITS'(MAG_MAX) : MAG_BITS'(rr);
                if (im_zero)
                begin
                    phase_reg <= (re_reg < 0) ? 16'sd32767 : 16'sd0;
                end
                else if (re_zero)
                begin
                    phase_reg <= (im_reg > 0) ? 16'sd16384 : -16'sd16384;
                end
                else if (pq > 64'sd32767)
                begin
                    phase_reg <= 16'sd32767;
                end
                else if (pq < -64'sd32768)
                begin
                    phase_reg <= -16'sd32768;
                end
                else
                begin
                    phase_reg <= PHASE_BITS'(pq);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign magnitude = mag_reg;
    assign phase     = phase_reg;

endmodule

`default_nettype wire

@@ hdl/fft_magnitude_phase_core.sv @@
// Top level of the FFT magnitude and phase core: frame loading, bit reversal,
// radix-2 butterflies and bin reads. Depends on fmp_pkg, fmp_ram and fmp_polar.
// Usage:
// The slave stream carries one transaction per item. With s_tuser low it loads
// the next real sample of the frame. The load that completes a frame of
// 2^log2_points samples starts the transform, during which s_tready is low: a
// bit-reversal pass over all N positions, swapping each pair once, then
// N/2 * log2(N) radix-2 butterflies, all through one multiplier and one port
// pair of the work store.
// With s_tuser high a transaction reads one bin below N/2 and yields one master
// transaction: m_tuser is 1 if the bin is valid, m_tdata holds magnitude and
// phase. A valid read runs the iterative square root and CORDIC unit, which
// first shifts a small bin value up for normalization, before m_tvalid rises;
// an invalid read skips that unit and goes straight to the output register.
// Loads are taken while a result waits on a stalled master side; a read waits
// until the output register is free. Reset sets log2_points to 10 and empties
// the frame; a configuration write restarts the frame.
`default_nettype none

module fft_magnitude_phase_core #(
    parameter int MAX_POINTS  = fmp_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = fmp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fmp_pkg::CFG_BITS-1:0]  cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // sample[15:0], bin_index[24:16]
    input  wire logic                          s_tuser,  // action
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [47:0]                   m_tdata,  // magnitude[25:0], phase[41:26]
    output logic                               m_tuser   // valid_res
);
    import fmp_pkg::*;

    localparam int TOP   = $clog2(MAX_POINTS);
    localparam int AW    = TOP;
    localparam int TWAW  = TOP - 1;
    localparam int TW_DEPTH = MAX_POINTS / 2;
    localparam int PB    = (SAMPLE_BITS + TOP + 1 > 32) ? 32 : SAMPLE_BITS + TOP + 1;
    localparam int LGW   = $clog2(TOP + 1);
    localparam int CMPW  = AW + BIN_W + 1;

    typedef logic [63:0] tw_rom_t [TW_DEPTH];

    function automatic tw_rom_t build_tw();
        tw_rom_t t;
        for (int k = 0; k < TW_DEPTH; k++) begin
            t[k] = tw_entry(k, TOP);
        end
        return t;
    endfunction

    localparam tw_rom_t TW_ROM = build_tw();

    localparam logic signed [PB+2:0] PART_HI = (PB+3)'((64'sd1 <<< (PB - 1)) - 1);
    localparam logic signed [PB+2:0] PART_LO = (PB+3)'(-(64'sd1 <<< (PB - 1)));

    function automatic logic signed [PB-1:0] sat_part(input logic signed [PB+2:0] v);
        logic signed [PB+2:0] r;
        r = (v > PART_HI) ? PART_HI : ((v < PART_LO) ? PART_LO : v);
        return PB'(r);
    endfunction

    fmp_state_t state_reg, state_next;

    logic [CFG_BITS-1:0] log2_reg;
    logic [AW-1:0]       cnt_reg, p_reg, base_reg, off_reg;
    logic [LGW-1:0]      stage_reg;
    logic                done_reg, ok_reg;
    logic [2*PB-1:0]     a_reg, b_reg;
    logic [63:0]         tw_q;
    logic signed [63:0]  prod_reg, acc_re_reg, acc_im_reg;
    logic signed [PB+1:0] t_re_reg, t_im_reg;
    logic                out_valid_reg, out_flag_reg;
    logic [MAG_BITS-1:0] out_mag_reg;
    logic [PHASE_BITS-1:0] out_phase_reg;

    logic [LGW-1:0]      lg;
    logic [AW:0]         n_full;
    logic [AW-1:0]       n_last, rev_full, br_r, half, lo, hi;
    logic                br_last, off_last, span_end, bf_last, bin_ok, out_free;
    logic                load_acc, read_acc;
    logic [TWAW-1:0]     tw_addr;
    logic [BIN_W-1:0]    bin;
    logic [SAMPLE_BITS-1:0] raw;
    logic signed [PB-1:0] samp;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [PB-1:0] a_re, a_im, b_re, b_im;
    logic signed [63:0]  rnd_re, rnd_im;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [2*PB-1:0]     ram_wdata, ram_rdata;
    logic                polar_start, polar_done;
    logic [MAG_BITS-1:0] polar_mag;
    logic signed [PHASE_BITS-1:0] polar_phase;

    always_comb
    begin
        if (log2_reg < CFG_BITS'(MIN_LOG2))
        begin
            lg = LGW'(MIN_LOG2);
        end
        else if (log2_reg > CFG_BITS'(TOP))
        begin
            lg = LGW'(TOP);
        end
        else
        begin
            lg = LGW'(log2_reg);
        end
    end

    always_comb
    begin
        for (int b = 0; b < AW; b++) begin
            rev_full[AW-1-b] = p_reg[b];
        end
    end

    assign n_full   = (AW+1)'(1) << lg;
    assign n_last   = AW'(n_full - 1'b1);
    assign br_r     = rev_full >> (LGW'(TOP) - lg);
    assign br_last  = (p_reg == n_last);
    assign half     = AW'(1) << (stage_reg - 1'b1);
    assign lo       = base_reg + off_reg;
    assign hi       = lo + half;
    assign off_last = (off_reg == half - 1'b1);
    assign span_end = ((AW+1)'(base_reg) + ((AW+1)'(half) << 1)) == n_full;
    assign bf_last  = off_last && span_end && (stage_reg == lg);
    assign tw_addr  = TWAW'(off_reg << (LGW'(TOP) - stage_reg));
    assign bin      = s_tdata[SAMPLE_W +: BIN_W];
    assign bin_ok   = CMPW'(bin) < CMPW'(n_full >> 1);
    assign raw      = SAMPLE_BITS'(s_tdata[SAMPLE_W-1:0]);
    assign samp     = PB'(signed'(raw));
    assign out_free = !out_valid_reg || m_tready;
    assign load_acc = s_tvalid && s_tready && (s_tuser == ACT_LOAD);
    assign read_acc = s_tvalid && s_tready && (s_tuser == ACT_READ);

    assign a_re = a_reg[PB-1:0];
    assign a_im = a_reg[2*PB-1:PB];
    assign b_re = b_reg[PB-1:0];
    assign b_im = b_reg[2*PB-1:PB];

    always_comb
    begin
        case (state_reg)
            ST_BF_M0, ST_BF_M2: mul_a = tw_q[31:0];
            default:            mul_a = tw_q[63:32];
        endcase
        case (state_reg)
            ST_BF_M0, ST_BF_M3: mul_b = 32'(b_re);
            default:            mul_b = 32'(b_im);
        endcase
    end

    assign rnd_re = acc_re_reg + (64'sd1 <<< (TW_FRAC - 1));
    assign rnd_im = acc_im_reg + (64'sd1 <<< (TW_FRAC - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        polar_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_raddr = AW'(bin);
                ram_waddr = cnt_reg;
                ram_wdata = {{PB{1'b0}}, samp};
                if (load_acc)
                begin
                    ram_we = 1'b1;
                    if (cnt_reg == n_last)
                    begin
                        state_next = ST_BR_CHK;
                    end
                end
                else if (read_acc)
                begin
                    state_next = (done_reg && bin_ok) ? ST_RD_LATCH : ST_RD_OUT;
                end
            end
            ST_BR_CHK:
            begin
                if (br_r > p_reg)
                begin
                    state_next = ST_BR_RD_P;
                end
                else if (br_last)
                begin
                    state_next = ST_BF_RD_HI;
                end
            end
            ST_BR_RD_P:
            begin
                ram_raddr  = p_reg;
                state_next = ST_BR_RD_R;
            end
            ST_BR_RD_R:
            begin
                ram_raddr  = br_r;
                state_next = ST_BR_WR_P;
            end
            ST_BR_WR_P:
            begin
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_BR_WR_R;
            end
            ST_BR_WR_R:
            begin
                ram_we     = 1'b1;
                ram_waddr  = br_r;
                ram_wdata  = a_reg;
                state_next = br_last ? ST_BF_RD_HI : ST_BR_CHK;
            end
            ST_BF_RD_HI:
            begin
                ram_raddr  = hi;
                state_next = ST_BF_RD_LO;
            end
            ST_BF_RD_LO:
            begin
                ram_raddr  = lo;
                state_next = ST_BF_M0;
            end
            ST_BF_M0:  state_next = ST_BF_M1;
            ST_BF_M1:  state_next = ST_BF_M2;
            ST_BF_M2:  state_next = ST_BF_M3;
            ST_BF_M3:  state_next = ST_BF_M4;
            ST_BF_M4:  state_next = ST_BF_RND;
            ST_BF_RND: state_next = ST_BF_WR_LO;
            ST_BF_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo;
                ram_wdata  = {sat_part((PB+3)'(a_im) + (PB+3)'(t_im_reg)),
                              sat_part((PB+3)'(a_re) + (PB+3)'(t_re_reg))};
                state_next = ST_BF_WR_HI;
            end
            ST_BF_WR_HI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi;
                ram_wdata  = {sat_part((PB+3)'(a_im) - (PB+3)'(t_im_reg)),
                              sat_part((PB+3)'(a_re) - (PB+3)'(t_re_reg))};
                state_next = bf_last ? ST_IDLE : ST_BF_RD_HI;
            end
            ST_RD_LATCH:
            begin
                polar_start = 1'b1;
                state_next  = ST_RD_POLAR;
            end
            ST_RD_POLAR:
            begin
                if (polar_done)
                begin
                    state_next = ST_RD_OUT;
                end
            end
            ST_RD_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg      <= CFG_BITS'(10);
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            p_reg         <= '0;
            stage_reg     <= LGW'(1);
            base_reg      <= '0;
            off_reg       <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                log2_reg <= cfg_wr_data;
                cnt_reg  <= '0;
                done_reg <= 1'b0;
            end
            else if (load_acc)
            begin
                done_reg <= 1'b0;
                cnt_reg  <= (cnt_reg == n_last) ? '0 : cnt_reg + 1'b1;
                p_reg    <= '0;
            end
            if (read_acc)
            begin
                ok_reg <= done_reg && bin_ok;
            end
            if ((state_reg == ST_BR_CHK && !(br_r > p_reg)) || state_reg == ST_BR_WR_R)
            begin
                if (br_last)
                begin
                    stage_reg <= LGW'(1);
                    base_reg  <= '0;
                    off_reg   <= '0;
                end
                else
                begin
                    p_reg <= p_reg + 1'b1;
                end
            end
            if (state_reg == ST_BF_WR_HI)
            begin
                if (bf_last)
                begin
                    done_reg <= 1'b1;
                end
                else if (off_last)
                begin
                    off_reg <= '0;
                    if (span_end)
                    begin
                        stage_reg <= stage_reg + 1'b1;
                        base_reg  <= '0;
                    end
                    else
                    begin
                        base_reg <= base_reg + (half << 1);
                    end
                end
                else
                begin
                    off_reg <= off_reg + 1'b1;
                end
            end
            if (state_reg == ST_RD_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tw_q     <= TW_ROM[tw_addr];
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_BR_RD_R:  a_reg <= ram_rdata;
            ST_BF_RD_LO: b_reg <= ram_rdata;
            ST_BF_M0:    a_reg <= ram_rdata;
            ST_BF_M1:    acc_re_reg <= prod_reg;
            ST_BF_M2:    acc_re_reg <= acc_re_reg + prod_reg;
            ST_BF_M3:    acc_im_reg <= prod_reg;
            ST_BF_M4:    acc_im_reg <= acc_im_reg - prod_reg;
            ST_BF_RND:
            begin
                t_re_reg <= (PB+2)'(rnd_re >>> TW_FRAC);
                t_im_reg <= (PB+2)'(rnd_im >>> TW_FRAC);
            end
            ST_RD_OUT:
            begin
                if (out_free)
                begin
                    out_flag_reg  <= ok_reg;
                    out_mag_reg   <= ok_reg ? polar_mag : '0;
                    out_phase_reg <= ok_reg ? polar_phase : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    fmp_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fmp_polar #(
        .PART_BITS (PB)
    ) u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (polar_start),
        .re        (ram_rdata[PB-1:0]),
        .im        (ram_rdata[2*PB-1:PB]),
        .done      (polar_done),
        .magnitude (polar_mag),
        .phase     (polar_phase)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tdata  = {6'b0, out_phase_reg, out_mag_reg};

    logic bf_active;
    assign bf_active = (state_reg >= ST_BF_RD_HI) && (state_reg <= ST_BF_WR_HI);

    a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= n_last)
        else $error("Load count beyond the frame size.");

    a_bf_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        bf_active |-> (stage_reg != '0 && stage_reg <= lg && (AW+1)'(hi) < n_full))
        else $error("Butterfly index outside the frame.");

    a_polar_waited: assert property (@(posedge clk) disable iff (!rst_n)
        polar_done |-> state_reg == ST_RD_POLAR)
        else $error("Polar unit finished while the sequencer was not waiting.");

    a_polar_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
        polar_start |=> !s_tready && ok_reg)
        else $error("Polar unit started for a read that is not valid.");

endmodule

`default_nettype wire
